// ===== design/fdm_pkg.sv =====
package fdm_pkg;

  // width of the raw sample field on the input channel
  localparam int SAMPLE_W = 12;

  localparam int WINDOW_DEPTH_DEF = 4;
  localparam int DELAY_DEPTH_DEF  = 4;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int PHASE_W       = 32;
  localparam int PRODUCT_SHIFT = 2;

  typedef logic [PHASE_W-1:0] phase_t;

  // phase advance per sample, one eighth of a turn
  localparam phase_t PLL_STEP = phase_t'(32'h2000_0000);

endpackage

// ===== design/fdm_if.sv =====
interface fdm_sample_if
  import fdm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fdm_bit_if
  import fdm_pkg::*;
  ();
  logic valid;
  logic ready;
  logic bit_res;

  modport source (output valid, output bit_res, input ready);
  modport sink   (input valid, input bit_res, output ready);
endinterface

// ===== design/fsk_delay_multiply_demodulator_top.sv =====
// AFSK demodulator, delay-and-multiply with a bit-timing phase loop.
// adc channel: one raw ADC sample per request (sample, low SAMPLE_BITS used).
// demod channel: one demodulated bit per request, issued once per bit period
// when the timing phase wraps from positive to negative; most samples give none.
// Two register stages: the sample is centred on the DC level and pushed into
// the delay line at acceptance; the product, filter and phase update run when
// stage two fires, which also registers any emitted bit in the output register.
// Throughput is one sample per cycle unless stage two holds; the filter and phase
// recurrences close within the second stage, around one 13x13 multiplier and one adder.
// The output register lets samples that produce no bit keep flowing while a
// bit waits; only a sample that would emit a second bit holds in stage two,
// which then backpressures the adc channel.
// Reset (rst, synchronous) clears the level window, delay line, filter,
// phase and last bit, and empties both stages; the window reads as zero
// until filled.
module fsk_delay_multiply_demodulator_top
  import fdm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fdm_sample_if.sink adc,
  fdm_bit_if.source  demod
);

  localparam int SIG_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * SIG_W - 1;
  localparam int X_W    = PROD_W - 1;
  localparam int Y_W    = X_W + 4;

  // stage one: level window and delay line
  logic [SAMPLE_BITS-1:0]  win [WINDOW_DEPTH-1];
  logic signed [SIG_W-1:0] dly [DELAY_DEPTH];

  logic [SAMPLE_BITS-1:0]  s;
  logic [SAMPLE_BITS-1:0]  mx;
  logic [SAMPLE_BITS-1:0]  mn;
  logic [SAMPLE_BITS:0]    lvl_sum;
  logic signed [SIG_W-1:0] sig;
  logic                    accept;

  // stage two registers
  logic                    v2;
  logic signed [SIG_W-1:0] sig2;
  logic signed [SIG_W-1:0] oldest2;

  // recurrence state
  logic signed [X_W-1:0] product_reg;
  logic signed [Y_W-1:0] filter_out;
  phase_t                pll_phase;
  logic                  last_bit;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [X_W-1:0]    x_now;
  logic signed [Y_W-1:0]    y_now;
  logic                     bit_now;
  phase_t                   ph_half;
  phase_t                   ph_next;
  logic                     emit;
  logic                     fire2;

  logic res_valid;
  logic res_bit;

  always_comb begin
    s = SAMPLE_BITS'(adc.sample);
    mx = s;
    mn = s;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      if (win[i] > mx) mx = win[i];
      if (win[i] < mn) mn = win[i];
    end
    lvl_sum = {1'b0, mx} + {1'b0, mn};
    sig = $signed({1'b0, s}) - $signed({1'b0, lvl_sum[SAMPLE_BITS:1]});
  end

  always_comb begin
    prod    = oldest2 * sig2;
    prod_sh = prod >>> PRODUCT_SHIFT;
    x_now   = X_W'(prod_sh);
    y_now   = Y_W'(product_reg) + Y_W'(x_now) + (filter_out >>> 1);
    bit_now = y_now[Y_W-1];
    ph_half = (bit_now != last_bit) ? {pll_phase[PHASE_W-1], pll_phase[PHASE_W-1:1]}
                                    : pll_phase;
    ph_next = ph_half + PLL_STEP;
    // positive (nonzero, sign clear) before the step, negative after
    emit    = ph_next[PHASE_W-1] && (ph_half != '0) && !ph_half[PHASE_W-1];
  end

  assign fire2     = v2 && (!emit || !res_valid || demod.ready);
  assign adc.ready = !v2 || fire2;
  assign accept    = adc.valid && adc.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) win[i] <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) dly[i] <= '0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        win[0] <= s;
        for (int i = 1; i < WINDOW_DEPTH - 1; i++) win[i] <= win[i-1];
        dly[0] <= sig;
        for (int i = 1; i < DELAY_DEPTH; i++) dly[i] <= dly[i-1];
      end
      if (adc.ready) v2 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sig2    <= sig;
      oldest2 <= dly[DELAY_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product_reg <= '0;
      filter_out  <= '0;
      pll_phase   <= '0;
      last_bit    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (fire2) begin
        product_reg <= x_now;
        filter_out  <= y_now;
        pll_phase   <= ph_next;
        last_bit    <= bit_now;
      end
      if (fire2 && emit) begin
        res_valid <= 1'b1;
      end else if (demod.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && emit) res_bit <= bit_now;
  end

  assign demod.valid   = res_valid;
  assign demod.bit_res = res_bit;

  // an emitted bit shows up in the output register with the filter sign
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    fire2 && emit |=> res_valid && (res_bit == $past(bit_now)))
    else $error("emitted bit not registered");

  // a held stage-two sample keeps its operands
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !fire2 |=> v2 && $stable(sig2) && $stable(oldest2))
    else $error("stage two sample lost while stalled");

  // recurrences move only when stage two fires
  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    !fire2 |=> $stable(filter_out) && $stable(pll_phase) && $stable(last_bit))
    else $error("filter or phase changed without a sample");

  // with no level change the phase advances by exactly one step
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    fire2 && (bit_now == last_bit) |=> pll_phase == $past(pll_phase) + PLL_STEP)
    else $error("phase advance wrong");

  // a bit is never emitted over a waiting one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !demod.ready |-> !(fire2 && emit))
    else $error("pending bit overwritten");

endmodule

// ===== test/fsk_delay_multiply_demodulator_top_test.sv =====
`timescale 1ns / 1ps

module fsk_delay_multiply_demodulator_top_test;
  import fdm_pkg::*;

  localparam int    CLK_HALF        = 4;
  localparam int    RESET_CYCLES    = 7;
  localparam int    SETTLE_CYCLES   = 8;
  localparam int    RX_HOLD_CYCLES  = 400;
  localparam int    SAMPLES_PER_BIT = 8;
  localparam int    CHUNK_ITEMS     = 125;
  localparam int    PRESSURE_ITEMS  = 60;
  localparam real   SAMPLE_RATE     = 9600.0;
  localparam real   MARK_HZ         = 1200.0;
  localparam real   SPACE_HZ        = 2200.0;
  localparam real   TWO_PI          = 6.283185307179586;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fdm_sample_if adc_ch ();
  fdm_bit_if    demod_ch ();

  fsk_delay_multiply_demodulator_top DUT (
    .clk   (clk),
    .rst   (rst),
    .adc   (adc_ch),
    .demod (demod_ch)
  );

  // samples waiting to be offered, demodulated bits waiting to come out
  logic [SAMPLE_W-1:0] pending[$];
  logic                bits_due[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_serial = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int fail_count  = 0;
  logic exp_bit;

  // predictor state
  logic [SAMPLE_BITS_DEF-1:0] lvl_win[WINDOW_DEPTH_DEF];
  int                         lvl_pos;
  logic signed [12:0]         cen_hist[DELAY_DEPTH_DEF];
  int                         cen_pos;
  logic signed [23:0]         prev_term;
  logic signed [27:0]         iir_out;
  phase_t                     bit_phase;
  logic                       prev_level;

  // tone generator state
  real tone_ph  = 0.0;
  int  tone_amp = 1000;
  int  tone_ofs = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void demod_reset();
    foreach (lvl_win[i]) lvl_win[i] = '0;
    foreach (cen_hist[i]) cen_hist[i] = '0;
    lvl_pos    = 0;
    cen_pos    = 0;
    prev_term  = '0;
    iir_out    = '0;
    bit_phase  = '0;
    prev_level = 1'b0;
  endfunction

  // one sample through level removal, delay-multiply, filter and timing loop
  function automatic void demod_step(input logic [SAMPLE_W-1:0] raw, output logic emit,
                                     output logic level);
    int     s, mx, mn, centred;
    longint oldest, x_now, y_now;
    phase_t before_adv;
    s = int'(raw) & ((1 << SAMPLE_BITS_DEF) - 1);
    lvl_win[lvl_pos] = s[SAMPLE_BITS_DEF-1:0];
    lvl_pos = (lvl_pos + 1) % WINDOW_DEPTH_DEF;
    mx = 0;
    mn = 1 << SAMPLE_BITS_DEF;
    foreach (lvl_win[i]) begin
      if (int'(lvl_win[i]) > mx) mx = int'(lvl_win[i]);
      if (int'(lvl_win[i]) < mn) mn = int'(lvl_win[i]);
    end
    centred = s - ((mx + mn) >> 1);
    oldest = longint'(cen_hist[cen_pos]);
    cen_hist[cen_pos] = centred[12:0];
    cen_pos = (cen_pos + 1) % DELAY_DEPTH_DEF;
    x_now = (oldest * longint'(centred)) >>> PRODUCT_SHIFT;
    y_now = longint'(prev_term) + x_now + (longint'(iir_out) >>> 1);
    prev_term = x_now[23:0];
    iir_out   = y_now[27:0];
    level = (y_now < 0);
    // halve the phase arithmetically on every level change
    if (level != prev_level) bit_phase = {bit_phase[PHASE_W-1], bit_phase[PHASE_W-1:1]};
    before_adv = bit_phase;
    bit_phase  = bit_phase + PLL_STEP;
    prev_level = level;
    emit = bit_phase[PHASE_W-1] && (before_adv != '0) && !before_adv[PHASE_W-1];
  endfunction

  task automatic push_tone(input int nsamp, input logic mark);
    real f;
    int  v;
    f = mark ? MARK_HZ : SPACE_HZ;
    repeat (nsamp) begin
      tone_ph = tone_ph + TWO_PI * f / SAMPLE_RATE;
      if (tone_ph > TWO_PI) tone_ph = tone_ph - TWO_PI;
      v = 2048 + tone_ofs + int'(tone_amp * $sin(tone_ph)) + $urandom_range(16) - 8;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      pending.push_back(v[SAMPLE_W-1:0]);
    end
  endtask

  // mostly clean afsk bursts with random data, some noise and cut-off tones
  task automatic push_traffic(input int count);
    int n, kind, len, nb;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        len = $urandom_range(1, 8);
        repeat (len) pending.push_back(SAMPLE_W'($urandom_range(4095)));
      end else if (kind == 1) begin
        len = $urandom_range(1, 5);
        push_tone(len, 1'($urandom_range(1)));
      end else begin
        tone_amp = $urandom_range(100, 2047);
        tone_ofs = $urandom_range(600) - 300;
        nb = $urandom_range(1, 4);
        len = nb * SAMPLES_PER_BIT;
        repeat (nb) push_tone(SAMPLES_PER_BIT, 1'($urandom_range(1)));
      end
      n += len;
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || adc_ch.valid || bits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: the predictor runs on every accepted request
  always @(posedge clk) begin
    if (rst) begin
      adc_ch.valid  <= 1'b0;
      adc_ch.sample <= '0;
    end else begin
      if (adc_ch.valid && adc_ch.ready) begin
        logic emit, level;
        demod_step(adc_ch.sample, emit, level);
        if (emit) bits_due.push_back(level);
      end
      if (!adc_ch.valid || adc_ch.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          adc_ch.valid  <= 1'b1;
          adc_ch.sample <= pending.pop_front();
        end else begin
          adc_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks demodulated bits and drives ready, with a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      demod_ch.ready <= 1'b0;
    end else begin
      if (demod_ch.valid && demod_ch.ready) begin
        if (bits_due.size() == 0) begin
          $error("bit_res: no bit expected, actual %0b", demod_ch.bit_res);
          fail_count++;
        end else begin
          exp_bit = bits_due.pop_front();
          if (demod_ch.bit_res !== exp_bit) begin
            $error("bit_res mismatch: expected %0b, actual %0b", exp_bit, demod_ch.bit_res);
            fail_count++;
          end
        end
      end
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        demod_ch.ready <= 1'b0;
      end else begin
        demod_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    adc_ch.valid   = 1'b0;
    adc_ch.sample  = '0;
    demod_ch.ready = 1'b0;
    demod_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 24;
    rx_idle_pct = 83;
    // extremes into a partly filled window, bit patterns, then a flat line
    // so the phase wraps to exactly zero without an emission
    pending.push_back(12'd4095);
    pending.push_back(12'd0);
    pending.push_back(12'd4095);
    pending.push_back(12'd0);
    pending.push_back(12'h555);
    pending.push_back(12'hAAA);
    pending.push_back(12'h555);
    pending.push_back(12'hAAA);
    repeat (10) pending.push_back(12'd2048);
    pending.push_back(12'd0);
    pending.push_back(12'd0);
    pending.push_back(12'd4095);
    pending.push_back(12'd4095);
    push_traffic(CHUNK_ITEMS);
    wait_drained();

    // receiver stalls while the sender keeps offering, then the sender waits it out
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_serial++;
    push_traffic(PRESSURE_ITEMS);
    wait_drained();

    tx_idle_pct = 83;
    rx_idle_pct = 24;
    push_traffic(CHUNK_ITEMS);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_traffic(CHUNK_ITEMS);
    wait_drained();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fdm_pkg.sv
design/fdm_if.sv
design/fsk_delay_multiply_demodulator_top.sv
test/fsk_delay_multiply_demodulator_top_test.sv
